FILE: rtl/timer_queue_manager_unit_defines.svh
// assertion helpers for the timer queue manager
`ifndef TIMER_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define TIMER_QUEUE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define TQM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TQM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tqm_pkg.sv
`default_nettype none
package tqm_pkg;
   localparam int TIMER_SLOTS = 16;
   localparam int TIME_BITS   = 48;
   localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(TIMER_SLOTS + 1);
   localparam int SUM_BITS    = TIME_BITS + 1;
   localparam int IVAL_BITS   = 32;
   localparam int SEQ_BITS    = 16;
   localparam int MAX_OUT     = 16;
   localparam int N_BITS      = $clog2(MAX_OUT + 1);
   localparam int EMIT_BITS   = $clog2(MAX_OUT);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNDEF  = 2'd3;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_CANCEL  = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOT_LIVE = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD, CELL_ADD, CELL_CANCEL, CELL_MARK, CELL_REARM
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [SLOT_BITS-1:0]  slot;
      logic [TIME_BITS-1:0]  expiry;
      logic [IVAL_BITS-1:0]  interval;
      logic [SEQ_BITS-1:0]   seq;
      logic [TIME_BITS-1:0]  now;
      logic                  pick_mode;
   } cell_cmd_type;

   typedef struct packed {
      logic                  min_found;
      logic [TIME_BITS-1:0]  min_key;
      logic [SLOT_BITS-1:0]  min_slot;
      logic [SEQ_BITS-1:0]   min_seq;
      logic                  free_found;
      logic [SLOT_BITS-1:0]  free_slot;
   } scan_type;
endpackage
`default_nettype wire

FILE: rtl/tqm_cell.sv
`default_nettype none
module tqm_cell import tqm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [SLOT_BITS-1:0] cell_index,
   input  wire cell_cmd_type         cmd,
   input  wire scan_type             scan_in,
   output scan_type                  scan_out,
   output logic                      cancel_hit
);
   logic                 live_ff, live_in;
   logic                 picked_ff, picked_in;
   logic [TIME_BITS-1:0] expiry_ff, expiry_in;
   logic [IVAL_BITS-1:0] interval_ff, interval_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   scan_type             scan_ff, scan_in_next;
   logic [SUM_BITS-1:0]  rearm_sum;
   logic                 here, cand;

   assign here       = (cmd.slot == cell_index);
   assign cancel_hit = (cmd.op == CELL_CANCEL) && here && live_ff && (seq_ff == cmd.seq);
   assign rearm_sum  = {1'b0, cmd.now} + SUM_BITS'(interval_ff);

   always_comb begin
      live_in     = live_ff;
      picked_in   = picked_ff;
      expiry_in   = expiry_ff;
      interval_in = interval_ff;
      seq_in      = seq_ff;
      case (cmd.op)
         CELL_ADD: begin
            if (here) begin
               live_in     = 1'b1;
               picked_in   = 1'b0;
               expiry_in   = cmd.expiry;
               interval_in = cmd.interval;
               seq_in      = cmd.seq;
            end
         end
         CELL_CANCEL: begin
            if (cancel_hit) live_in = 1'b0;
         end
         CELL_MARK: begin
            if (here) picked_in = 1'b1;
         end
         CELL_REARM: begin
            if (picked_ff) begin
               picked_in = 1'b0;
               if (interval_ff != '0) begin
                  // saturate at the largest time value
                  expiry_in = rearm_sum[TIME_BITS] ? '1 : rearm_sum[TIME_BITS-1:0];
               end else begin
                  live_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // min and first-free search, one cell per cycle along the chain
   always_comb begin
      scan_in_next = scan_in;
      cand = cmd.pick_mode ? (live_ff && !picked_ff && (expiry_ff <= cmd.now)) : live_ff;
      if (cand && (!scan_in.min_found || (expiry_ff < scan_in.min_key))) begin
         scan_in_next.min_found = 1'b1;
         scan_in_next.min_key   = expiry_ff;
         scan_in_next.min_slot  = cell_index;
         scan_in_next.min_seq   = seq_ff;
      end
      if (!live_ff && !scan_in.free_found) begin
         scan_in_next.free_found = 1'b1;
         scan_in_next.free_slot  = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= 1'b0;
         picked_ff <= 1'b0;
      end else begin
         live_ff   <= live_in;
         picked_ff <= picked_in;
      end
      expiry_ff   <= expiry_in;
      interval_ff <= interval_in;
      seq_ff      <= seq_in;
      scan_ff     <= scan_in_next;
   end

   assign scan_out = scan_ff;
endmodule
`default_nettype wire

FILE: rtl/timer_queue_manager_unit.sv
// channel   | direction | handshake
// request   | in        | start, taken when busy is low
// response  | out       | rsp_valid strobe, one cycle per result
// one search pass walks the cell chain
// add: one pass; cancel: the S_CANCEL state, then one pass
// tick with k expired: (k + 2) passes, or k + 1 passes when k is MAX_OUT,
// then the S_EMIT state sends max(k, 1) results
// synchronous active-high reset clears all timers and the sequence counter
// results go out back to back and cannot be stalled
`default_nettype none
`include "timer_queue_manager_unit_defines.svh"
module timer_queue_manager_unit import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [47:0] req_expiry_time,
   input  wire logic [31:0] req_repeat_interval,
   input  wire logic [3:0]  req_handle_slot,
   input  wire logic [15:0] req_handle_sequence,
   input  wire logic [47:0] req_now_time,
   output logic             rsp_valid,
   output logic [1:0]       rsp_result_kind,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_out_slot,
   output logic [15:0]      rsp_out_sequence,
   output logic             rsp_earliest_changed,
   output logic             rsp_next_valid,
   output logic [47:0]      rsp_next_deadline,
   output logic             rsp_last
);
   typedef enum logic [2:0] {S_IDLE, S_CANCEL, S_SCAN, S_REARM, S_EMIT} state_type;

   state_type            state_ff;
   logic [1:0]           op_ff;
   logic                 final_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [N_BITS-1:0]    n_ff;
   logic [EMIT_BITS-1:0] emit_ff;
   logic [TIME_BITS-1:0] expiry_ff, now_ff;
   logic [IVAL_BITS-1:0] interval_ff;
   logic [3:0]           hslot_ff;
   logic [SEQ_BITS-1:0]  hseq_ff, seq_counter_ff;
   logic [1:0]           status_ff;
   logic                 nv_ff;
   logic [TIME_BITS-1:0] dl_ff;
   logic [SLOT_BITS-1:0] order_ff [MAX_OUT];
   logic [SEQ_BITS-1:0]  oseq_ff [MAX_OUT];

   logic                 rsp_valid_ff, rsp_earliest_ff, rsp_nv_ff, rsp_last_ff;
   logic [1:0]           rsp_kind_ff, rsp_status_ff;
   logic [3:0]           rsp_slot_ff;
   logic [SEQ_BITS-1:0]  rsp_seq_ff;
   logic [47:0]          rsp_dl_ff;

   cell_cmd_type         cmd;
   scan_type             chain [TIMER_SLOTS+1];
   logic [TIMER_SLOTS-1:0] hit_vec;
   scan_type             res;
   logic                 scan_done, hs_ok, cancel_hit;
   logic [TIME_BITS-1:0] add_dl;

   assign chain[0]   = '0;
   assign res        = chain[TIMER_SLOTS];
   assign scan_done  = (cnt_ff == CNT_BITS'(TIMER_SLOTS));
   assign hs_ok      = (32'(hslot_ff) < TIMER_SLOTS);
   assign cancel_hit = |hit_vec;
   assign add_dl     = (res.min_found && (res.min_key < expiry_ff)) ? res.min_key : expiry_ff;

   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      tqm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_BITS'(i)),
         .cmd        (cmd),
         .scan_in    (chain[i]),
         .scan_out   (chain[i+1]),
         .cancel_hit (hit_vec[i])
      );
   end

   always_comb begin
      cmd.op        = CELL_HOLD;
      cmd.slot      = SLOT_BITS'(hslot_ff);
      cmd.expiry    = expiry_ff;
      cmd.interval  = interval_ff;
      cmd.seq       = hseq_ff;
      cmd.now       = now_ff;
      cmd.pick_mode = (op_ff == OP_TICK) && !final_ff;
      case (state_ff)
         S_CANCEL: begin
            if (hs_ok) cmd.op = CELL_CANCEL;
         end
         S_SCAN: begin
            if (scan_done && (op_ff == OP_ADD) && res.free_found) begin
               cmd.op   = CELL_ADD;
               cmd.slot = res.free_slot;
               cmd.seq  = seq_counter_ff;
            end else if (scan_done && cmd.pick_mode && res.min_found) begin
               cmd.op   = CELL_MARK;
               cmd.slot = res.min_slot;
            end
         end
         S_REARM: cmd.op = CELL_REARM;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         seq_counter_ff <= '0;
         cnt_ff         <= '0;
         n_ff           <= '0;
         emit_ff        <= '0;
         final_ff       <= 1'b0;
         op_ff          <= OP_ADD;
      end else begin
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  op_ff       <= req_operation;
                  expiry_ff   <= TIME_BITS'(req_expiry_time);
                  now_ff      <= TIME_BITS'(req_now_time);
                  interval_ff <= req_repeat_interval;
                  hslot_ff    <= req_handle_slot;
                  hseq_ff     <= req_handle_sequence;
                  cnt_ff      <= '0;
                  n_ff        <= '0;
                  emit_ff     <= '0;
                  case (req_operation)
                     OP_ADD: begin
                        final_ff <= 1'b1;
                        state_ff <= S_SCAN;
                     end
                     OP_CANCEL: state_ff <= S_CANCEL;
                     OP_TICK: begin
                        final_ff <= 1'b0;
                        state_ff <= S_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            S_CANCEL: begin
               rsp_valid_ff <= 1'b0;
               status_ff    <= cancel_hit ? ST_OK : ST_NOT_LIVE;
               final_ff     <= 1'b1;
               state_ff     <= S_SCAN;
            end
            S_SCAN: begin
               rsp_valid_ff <= scan_done && (op_ff != OP_TICK);
               if (scan_done) begin
                  cnt_ff <= '0;
                  case (op_ff)
                     OP_ADD: begin
                        rsp_kind_ff     <= KIND_ADD;
                        rsp_last_ff     <= 1'b1;
                        if (res.free_found) begin
                           rsp_status_ff   <= ST_OK;
                           rsp_slot_ff     <= 4'(res.free_slot);
                           rsp_seq_ff      <= seq_counter_ff;
                           rsp_earliest_ff <= !res.min_found || (expiry_ff < res.min_key);
                           rsp_nv_ff       <= 1'b1;
                           rsp_dl_ff       <= 48'(add_dl);
                           seq_counter_ff  <= seq_counter_ff + 1'b1;
                        end else begin
                           rsp_status_ff   <= ST_FULL;
                           rsp_slot_ff     <= '0;
                           rsp_seq_ff      <= '0;
                           rsp_earliest_ff <= 1'b0;
                           rsp_nv_ff       <= res.min_found;
                           rsp_dl_ff       <= res.min_found ? 48'(res.min_key) : '0;
                        end
                        state_ff <= S_IDLE;
                     end
                     OP_CANCEL: begin
                        rsp_kind_ff     <= KIND_CANCEL;
                        rsp_status_ff   <= status_ff;
                        rsp_slot_ff     <= hslot_ff;
                        rsp_seq_ff      <= hseq_ff;
                        rsp_earliest_ff <= 1'b0;
                        rsp_nv_ff       <= res.min_found;
                        rsp_dl_ff       <= res.min_found ? 48'(res.min_key) : '0;
                        rsp_last_ff     <= 1'b1;
                        state_ff        <= S_IDLE;
                     end
                     default: begin
                        if (final_ff) begin
                           nv_ff    <= res.min_found;
                           dl_ff    <= res.min_key;
                           state_ff <= S_EMIT;
                        end else if (res.min_found) begin
                           order_ff[EMIT_BITS'(n_ff)] <= res.min_slot;
                           oseq_ff[EMIT_BITS'(n_ff)]  <= res.min_seq;
                           n_ff <= n_ff + 1'b1;
                           if (n_ff + 1'b1 == N_BITS'(MAX_OUT)) state_ff <= S_REARM;
                        end else begin
                           state_ff <= S_REARM;
                        end
                     end
                  endcase
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_REARM: begin
               rsp_valid_ff <= 1'b0;
               final_ff     <= 1'b1;
               cnt_ff       <= '0;
               state_ff     <= S_SCAN;
            end
            S_EMIT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_status_ff   <= ST_OK;
               rsp_earliest_ff <= 1'b0;
               rsp_nv_ff       <= nv_ff;
               rsp_dl_ff       <= nv_ff ? 48'(dl_ff) : '0;
               if (n_ff == '0) begin
                  rsp_kind_ff <= KIND_NONE;
                  rsp_slot_ff <= '0;
                  rsp_seq_ff  <= '0;
                  rsp_last_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  rsp_kind_ff <= KIND_EXPIRED;
                  rsp_slot_ff <= 4'(order_ff[emit_ff]);
                  rsp_seq_ff  <= oseq_ff[emit_ff];
                  rsp_last_ff <= (N_BITS'(emit_ff) + 1'b1 == n_ff);
                  emit_ff     <= emit_ff + 1'b1;
                  if (N_BITS'(emit_ff) + 1'b1 == n_ff) state_ff <= S_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_kind_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_slot         = rsp_slot_ff;
   assign rsp_out_sequence     = rsp_seq_ff;
   assign rsp_earliest_changed = rsp_earliest_ff;
   assign rsp_next_valid       = rsp_nv_ff;
   assign rsp_next_deadline    = rsp_dl_ff;
   assign rsp_last             = rsp_last_ff;

   `TQM_ASSERT_NOW(a_last_ends_busy, rsp_valid && rsp_last, !busy, "busy after final result")
   `TQM_ASSERT_NOW(a_more_keeps_busy, rsp_valid && !rsp_last, busy, "idle before final result")
   `TQM_ASSERT_NEXT(a_accept_busy, start && !busy && (req_operation != OP_UNDEF), busy,
      "transfer did not start work")
   `TQM_ASSERT_NOW(a_add_armed, rsp_valid && (rsp_result_kind == KIND_ADD) &&
      (rsp_status == ST_OK), rsp_next_valid, "add left no timer armed")
endmodule
`default_nettype wire

FILE: tb/sv/timer_queue_checker.sv
`default_nettype none
module timer_queue_checker import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [47:0] req_expiry_time,
   input  wire logic [31:0] req_repeat_interval,
   input  wire logic [3:0]  req_handle_slot,
   input  wire logic [15:0] req_handle_sequence,
   input  wire logic [47:0] req_now_time,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_result_kind,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [3:0]  rsp_out_slot,
   input  wire logic [15:0] rsp_out_sequence,
   input  wire logic        rsp_earliest_changed,
   input  wire logic        rsp_next_valid,
   input  wire logic [47:0] rsp_next_deadline,
   input  wire logic        rsp_last,
   output int               fail_count,
   output int               outstanding
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [15:0] seq;
      logic        earliest;
      logic        nvalid;
      logic [47:0] deadline;
      logic        last;
   } timer_event_type;

   localparam logic [47:0] TIME_TOP = '1;

   logic        live[TIMER_SLOTS];
   logic [47:0] expiry[TIMER_SLOTS];
   logic [31:0] interval[TIMER_SLOTS];
   logic [15:0] seqno[TIMER_SLOTS];
   logic [15:0] seq_counter;
   timer_event_type pending_events[$];

   function automatic logic earliest_deadline(output logic [47:0] dl);
      logic any;
      any = 1'b0;
      dl = '0;
      for (int i = 0; i < TIMER_SLOTS; i++)
         if (live[i] && (!any || expiry[i] < dl)) begin
            dl = expiry[i];
            any = 1'b1;
         end
      return any;
   endfunction

   function automatic timer_event_type make_event(logic [1:0] kind, logic [1:0] st,
         logic [3:0] slot, logic [15:0] sq, logic ec, logic lst);
      timer_event_type e;
      logic [47:0] dl;
      e.kind = kind;
      e.status = st;
      e.slot = slot;
      e.seq = sq;
      e.earliest = ec;
      e.nvalid = earliest_deadline(dl);
      e.deadline = e.nvalid ? dl : '0;
      e.last = lst;
      return e;
   endfunction

   task automatic predict_timer_events();
      int free_slot;
      logic [47:0] dl;
      logic ec;
      logic picked[TIMER_SLOTS];
      int order[$];
      logic [15:0] seqs[$];
      int best;
      case (req_operation)
         OP_ADD: begin
            free_slot = -1;
            for (int i = TIMER_SLOTS - 1; i >= 0; i--)
               if (!live[i]) free_slot = i;
            if (free_slot < 0)
               pending_events.push_back(make_event(KIND_ADD, ST_FULL, '0, '0, 1'b0, 1'b1));
            else begin
               ec = !earliest_deadline(dl) || req_expiry_time < dl;
               live[free_slot] = 1'b1;
               expiry[free_slot] = req_expiry_time;
               interval[free_slot] = req_repeat_interval;
               seqno[free_slot] = seq_counter;
               seq_counter = seq_counter + 1'b1;
               pending_events.push_back(make_event(KIND_ADD, ST_OK, 4'(free_slot),
                  seqno[free_slot], ec, 1'b1));
            end
         end
         OP_CANCEL: begin
            if (live[req_handle_slot] && seqno[req_handle_slot] == req_handle_sequence) begin
               live[req_handle_slot] = 1'b0;
               pending_events.push_back(make_event(KIND_CANCEL, ST_OK, req_handle_slot,
                  req_handle_sequence, 1'b0, 1'b1));
            end else
               pending_events.push_back(make_event(KIND_CANCEL, ST_NOT_LIVE,
                  req_handle_slot, req_handle_sequence, 1'b0, 1'b1));
         end
         OP_TICK: begin
            for (int i = 0; i < TIMER_SLOTS; i++) picked[i] = 1'b0;
            while (order.size() < MAX_OUT) begin
               best = -1;
               for (int i = 0; i < TIMER_SLOTS; i++)
                  if (live[i] && !picked[i] && expiry[i] <= req_now_time &&
                      (best < 0 || expiry[i] < expiry[best]))
                     best = i;
               if (best < 0) break;
               picked[best] = 1'b1;
               order.push_back(best);
               seqs.push_back(seqno[best]);
            end
            foreach (order[k]) begin
               if (interval[order[k]] != 0)
                  expiry[order[k]] = (TIME_TOP - req_now_time < {16'd0, interval[order[k]]})
                     ? TIME_TOP : req_now_time + interval[order[k]];
               else
                  live[order[k]] = 1'b0;
            end
            if (order.size() == 0)
               pending_events.push_back(make_event(KIND_NONE, ST_OK, '0, '0, 1'b0, 1'b1));
            foreach (order[k])
               pending_events.push_back(make_event(KIND_EXPIRED, ST_OK, 4'(order[k]), seqs[k],
                  1'b0, k == order.size() - 1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      timer_event_type got;
      timer_event_type want;
      if (reset) begin
         for (int i = 0; i < TIMER_SLOTS; i++) live[i] = 1'b0;
         seq_counter = '0;
         pending_events.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_result_kind, rsp_status, rsp_out_slot, rsp_out_sequence,
                    rsp_earliest_changed, rsp_next_valid, rsp_next_deadline, rsp_last};
            if (pending_events.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_events.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch expected %p actual %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) predict_timer_events();
      end
      outstanding <= pending_events.size();
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_timer_queue_manager_unit.sv
`default_nettype none
module tb_timer_queue_manager_unit import tqm_pkg::*;;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 345;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_operation = OP_TICK;
   logic [47:0] req_expiry_time = '0;
   logic [31:0] req_repeat_interval = '0;
   logic [3:0]  req_handle_slot = '0;
   logic [15:0] req_handle_sequence = '0;
   logic [47:0] req_now_time = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_out_slot;
   logic [15:0] rsp_out_sequence;
   logic        rsp_earliest_changed;
   logic        rsp_next_valid;
   logic [47:0] rsp_next_deadline;
   logic        rsp_last;
   int          fail_count;
   int          outstanding;
   int          cycles = 0;
   logic [19:0] handles[$];
   logic [47:0] sim_now = 48'd1000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   timer_queue_manager_unit i_dut (.*);
   timer_queue_checker i_checker (.*);

   // remember granted handles so most cancels use handles the unit gave out
   always @(posedge clock)
      if (rsp_valid && rsp_result_kind == KIND_ADD && rsp_status == ST_OK) begin
         handles.push_back({rsp_out_slot, rsp_out_sequence});
         if (handles.size() > 32) void'(handles.pop_front());
      end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL timer_queue_manager_unit");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, logic [47:0] exp_t, logic [31:0] ivl,
         logic [3:0] hs, logic [15:0] hq, logic [47:0] now_t);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_expiry_time <= exp_t;
      req_repeat_interval <= ivl;
      req_handle_slot <= hs;
      req_handle_sequence <= hq;
      req_now_time <= now_t;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
   endfunction

   initial begin
      logic [47:0] t;
      logic [19:0] h;
      int sel;
      int count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, saturation, bad handles, table full
      send(OP_TICK, '0, '0, '0, '0, '0);
      send(OP_ADD, '0, '0, '0, '0, '0);
      send(OP_ADD, '1, '1, '0, '0, '0);
      send(OP_ADD, 48'd500, 32'd100, '0, '0, '0);
      send(OP_CANCEL, '0, '0, 4'd1, 16'd5, '0);
      send(OP_CANCEL, '0, '0, 4'd15, 16'hFFFF, '0);
      send(OP_TICK, '0, '0, '0, '0, 48'd600);
      send(OP_UNDEF, '1, '1, '1, '1, '1);
      send(OP_TICK, '0, '0, '0, '0, '1);
      send(OP_CANCEL, '0, '0, 4'd1, 16'd1, '0);
      for (int i = 0; i < 15; i++)
         send(OP_ADD, 48'd2000 - i, i[0] ? 32'd0 : 32'd7, '0, '0, '0);
      send(OP_ADD, 48'd10, '0, '0, '0, '0);
      send(OP_TICK, '0, '0, '0, '0, 48'd5000);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            t = ($urandom_range(19) == 0) ? rand48() : sim_now + $urandom_range(300);
            send(OP_ADD, t, ($urandom_range(9) == 0) ? $urandom() :
               ($urandom_range(1) ? 32'd0 : $urandom_range(200)), '0, '0, '0);
         end else if (sel < 65) begin
            if (handles.size() > 0 && $urandom_range(9) < 7) begin
               h = handles[$urandom_range(handles.size() - 1)];
               send(OP_CANCEL, '0, '0, h[19:16], h[15:0], '0);
            end else
               send(OP_CANCEL, '0, '0, 4'($urandom_range(15)),
                  16'($urandom_range(16'hFFFF)), '0);
         end else if (sel < 98) begin
            sim_now = sim_now + $urandom_range(150);
            send(OP_TICK, '0, '0, '0, '0, ($urandom_range(24) == 0) ? rand48() : sim_now);
         end else
            send(OP_UNDEF, rand48(), $urandom(), 4'($urandom_range(15)),
               16'($urandom_range(16'hFFFF)), rand48());
         if (sel < 98) count++;
         if (count == RANDOM_ITEMS / 2) begin
            // hold off until every outstanding result has arrived
            pause(1);
            while (outstanding != 0) @(posedge clock);
         end
         if (count < RANDOM_ITEMS - 60 && $urandom_range(3) == 0)
            pause($urandom_range(19, 1));
      end
      pause(1);
      while (outstanding != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("PASS timer_queue_manager_unit");
      else
         $display("FAIL timer_queue_manager_unit");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/tqm_pkg.sv
rtl/tqm_cell.sv
rtl/timer_queue_manager_unit.sv
tb/sv/timer_queue_checker.sv
tb/sv/tb_timer_queue_manager_unit.sv
